// ===== hdl/jtss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Java type signature scanner.
// Used by jtss_stack, java_type_signature_scanner and its checker.
package jtss_pkg;

    // Depth of the mark stack and the widths that follow from it
    localparam int NEST_DEPTH = 32;
    localparam int LEVEL_W    = $clog2(NEST_DEPTH + 1);
    localparam int IDX_W      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int CNT_W      = 16;

    // Signature characters
    localparam logic [7:0] CH_BRACKET = 8'h5B; // '['
    localparam logic [7:0] CH_L       = 8'h4C; // 'L'
    localparam logic [7:0] CH_SEMI    = 8'h3B; // ';'
    localparam logic [7:0] CH_LT      = 8'h3C; // '<'
    localparam logic [7:0] CH_GT      = 8'h3E; // '>'
    localparam logic [7:0] CH_V       = 8'h56; // 'V'
    localparam logic [7:0] CH_STAR    = 8'h2A; // '*'

    typedef enum logic [2:0] {
        ST_MORE        = 3'd0,
        ST_DONE        = 3'd1,
        ST_MISMATCH    = 3'd2,
        ST_BAD_GENERIC = 3'd3,
        ST_BAD_TOP     = 3'd4,
        ST_TRUNCATED   = 3'd5,
        ST_OVERFLOW    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_BRACKETS = 2'd1,
        MODE_BODY     = 2'd2
    } t_mode;

    typedef enum logic {
        MARK_L     = 1'b0,
        MARK_ANGLE = 1'b1
    } t_mark;

    // One stack operation per accepted item; clear is applied before push or pop
    typedef struct packed {
        logic  clear;
        logic  push;
        logic  pop;
        t_mark mark;
    } t_stack_cmd;

    // What the decoder sees of the stack
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_mark              top;
    } t_stack_view;

endpackage

// ===== hdl/jtss_stack.sv =====
`timescale 1ns / 1ps
// Mark stack: entries in a synchronous RAM, the top mark in a register.
// Depends on jtss_pkg.
module jtss_stack
    import jtss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stack_cmd  i_cmd,
    output t_stack_view o_view
);

    t_mark              mem [NEST_DEPTH];
    t_mark              r_rd;
    t_mark              r_top;
    t_mark              n_top;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic [LEVEL_W-1:0] base;
    logic [LEVEL_W-1:0] below;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;

    // Compute the new level and top; the entry under the new top is prefetched
    always_comb begin
        base    = i_cmd.clear ? '0 : r_level;
        n_level = base;
        n_top   = i_cmd.clear ? MARK_L : r_top;
        if (i_cmd.push) begin
            n_level = base + LEVEL_W'(1);
            n_top   = i_cmd.mark;
        end else if (i_cmd.pop) begin
            n_level = base - LEVEL_W'(1);
            // r_rd holds the entry just below the current top
            n_top   = (base >= LEVEL_W'(2)) ? r_rd : MARK_L;
        end
        below   = n_level - LEVEL_W'(2);
        rd_addr = below[IDX_W-1:0];
        wr_addr = base[IDX_W-1:0];
    end

    // Write on push, read below the new top every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[wr_addr] <= i_cmd.mark;
        end
        r_rd <= mem[rd_addr];
    end

    // Hold level and top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_top   <= MARK_L;
        end else begin
            r_level <= n_level;
            r_top   <= n_top;
        end
    end

    assign o_view.level = r_level;
    assign o_view.top   = r_top;

endmodule

// ===== hdl/java_type_signature_scanner.sv =====
`timescale 1ns / 1ps
// Java type signature scanner, top level.
// Depends on jtss_pkg and jtss_stack.
//
// Usage:
//   The input channel takes one signature byte per item (i_char_in) with
//   i_last_byte set on the last byte available in the buffer. Every item
//   yields exactly one result item: o_status and o_consumed.
//   A pass skips a run of '[' and then takes 'V' or an 'L' body; inside the
//   body a stack of open 'L' and '<' marks is kept. Any status other than
//   "more" ends the pass and the next byte starts a new one.
// Throughput:
//   One item per cycle while o_in_stall is low. Each result goes to the
//   output register, or to the skid entry if the output is held. The
//   stack top sits in a register and the entry below it is read ahead from
//   the mark RAM, so back-to-back pops and pushes run without a bubble.
// Stall:
//   The output register is backed by one skid entry. When the receiver
//   stalls, one more item is taken into the skid entry, then o_in_stall
//   rises until the output drains.
// Reset:
//   Synchronous, active low. Clears mode, stack level, byte count and both
//   output slots; the mark RAM keeps its content and needs no clearing.
module java_type_signature_scanner
    import jtss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_char_in,
    input  logic             i_last_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [CNT_W-1:0] o_consumed
);

    t_mode             r_mode;
    t_mode             n_mode;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  cnt_inc;
    t_status           status;
    logic [CNT_W-1:0]  consumed;
    t_stack_cmd        cmd;
    t_stack_cmd        stack_cmd;
    t_stack_view       view;
    logic              in_acc;
    logic              out_take;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [CNT_W-1:0]  r_out_consumed;
    logic              r_skid_valid;
    t_status           r_skid_status;
    logic [CNT_W-1:0]  r_skid_consumed;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    // Count this byte, saturating
    assign cnt_inc = (r_count == {CNT_W{1'b1}}) ? r_count : r_count + CNT_W'(1);

    // Decode the byte against mode and stack top
    always_comb begin
        status = ST_MORE;
        cmd    = '0;
        if (r_mode != MODE_BODY) begin
            unique case (i_char_in)
                CH_BRACKET: ;
                CH_V:       status = ST_DONE;
                CH_L: begin
                    cmd.clear = 1'b1;
                    cmd.push  = 1'b1;
                    cmd.mark  = MARK_L;
                end
                default:    status = ST_BAD_TOP;
            endcase
        end else begin
            unique case (i_char_in)
                CH_SEMI: begin
                    cmd.pop = 1'b1;
                    if (view.top != MARK_L) begin
                        status = ST_MISMATCH;
                    end else if (view.level == LEVEL_W'(1)) begin
                        status = ST_DONE;
                    end
                end
                CH_LT: begin
                    if (view.level == LEVEL_W'(NEST_DEPTH)) begin
                        status = ST_OVERFLOW;
                    end else begin
                        cmd.push = 1'b1;
                        cmd.mark = MARK_ANGLE;
                    end
                end
                CH_GT: begin
                    cmd.pop = 1'b1;
                    if (view.top != MARK_ANGLE) begin
                        status = ST_MISMATCH;
                    end
                end
                default: begin
                    if (view.top == MARK_L) begin
                        // part of the class name
                    end else if (i_char_in == CH_L) begin
                        if (view.level == LEVEL_W'(NEST_DEPTH)) begin
                            status = ST_OVERFLOW;
                        end else begin
                            cmd.push = 1'b1;
                            cmd.mark = MARK_L;
                        end
                    end else if (i_char_in == CH_V || i_char_in == CH_STAR) begin
                        // accepted inside generics
                    end else begin
                        status = ST_BAD_GENERIC;
                    end
                end
            endcase
        end

        if (status == ST_MORE && i_last_byte) begin
            status = ST_TRUNCATED;
        end
        // End of pass: drop the stack
        if (status != ST_MORE) begin
            cmd.clear = 1'b1;
            cmd.push  = 1'b0;
            cmd.pop   = 1'b0;
        end

        if (status == ST_MORE || status == ST_BAD_TOP || status == ST_TRUNCATED) begin
            consumed = '0;
        end else begin
            consumed = cnt_inc;
        end
    end

    // Apply stack operations only for accepted items
    assign stack_cmd = in_acc ? cmd : '0;

    jtss_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stack_cmd),
        .o_view  (view)
    );

    // Next mode and byte count
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        if (in_acc) begin
            if (status != ST_MORE) begin
                n_mode  = MODE_IDLE;
                n_count = '0;
            end else begin
                n_count = cnt_inc;
                if (r_mode != MODE_BODY) begin
                    if (i_char_in == CH_BRACKET) begin
                        n_mode = MODE_BRACKETS;
                    end else if (i_char_in == CH_L) begin
                        n_mode = MODE_BODY;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_status   <= r_skid_status;
                r_out_consumed <= r_skid_consumed;
            end else if (in_acc) begin
                r_out_status   <= status;
                r_out_consumed <= consumed;
            end
        end else if (in_acc) begin
            r_skid_status   <= status;
            r_skid_consumed <= consumed;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_consumed  = r_out_consumed;

endmodule

// ===== hdl/jtss_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for java_type_signature_scanner, bound to the top level.
// Depends on jtss_pkg.
module jtss_checker
    import jtss_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [2:0]       o_status,
    input logic [CNT_W-1:0] o_consumed
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_consumed))
        else $error("stalled result changed");

    // After an accepted item the output is valid next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item gave no result");

    // Status codes stay within range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 3'd7)
        else $error("status out of range");

    // No consumed length for more, bad top type or truncated
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_MORE || o_status == ST_BAD_TOP
            || o_status == ST_TRUNCATED) |-> o_consumed == '0)
        else $error("consumed nonzero for status without length");

    // Done always counts at least one byte
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_DONE |-> o_consumed != '0)
        else $error("done with zero length");

endmodule

bind java_type_signature_scanner jtss_checker u_jtss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_consumed  (o_consumed)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for java_type_signature_scanner: a directed table, then random
// signature streams; each result is checked against a typed row or a local scanner model.
// Depends on jtss_pkg and the RTL top level.
module tb_top
    import jtss_pkg::*;
();

    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AFTER     = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DIR_ROWS       = 25;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [7:0] CH_LOWER_X = 8'h78; // 'x', not legal inside generics

    typedef struct packed {
        t_status          st;
        logic [CNT_W-1:0] cons;
    } t_scan_result;

    typedef struct packed {
        logic [7:0]       ch;
        logic             last;
        logic             typed;
        t_status          st;
        logic [CNT_W-1:0] cons;
    } t_dir_row;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [7:0]       char_in   = 8'h00;
    logic             last_byte = 1'b0;
    logic             out_stall = 1'b0;
    wire              in_stall;
    wire              out_valid;
    wire  [2:0]       status;
    wire  [CNT_W-1:0] consumed;

    // Scanner model state
    t_mode            sig_mode;
    t_mark            mark_stack [NEST_DEPTH];
    int               mark_level;
    logic [CNT_W-1:0] pass_bytes;

    t_scan_result     pending_results [$];
    logic [8:0]       seq_bytes [$];
    int               n_fail     = 0;
    int               n_items_in = 0;
    logic             burst      = 1'b0;

    // Directed rows: typed expectation where obvious, model otherwise
    t_dir_row directed_rows [DIR_ROWS] = '{
        '{CH_V,       1'b0, 1'b1, ST_DONE,        16'd1},
        '{CH_V,       1'b1, 1'b1, ST_DONE,        16'd1},
        '{8'h00,      1'b0, 1'b1, ST_BAD_TOP,     16'd0},
        '{8'hFF,      1'b1, 1'b1, ST_BAD_TOP,     16'd0},
        '{CH_BRACKET, 1'b0, 1'b1, ST_MORE,        16'd0},
        '{CH_V,       1'b0, 1'b1, ST_DONE,        16'd2},
        '{CH_BRACKET, 1'b1, 1'b1, ST_TRUNCATED,   16'd0},
        '{CH_L,       1'b0, 1'b1, ST_MORE,        16'd0},
        '{8'hFF,      1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_LT,      1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_STAR,    1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_L,       1'b0, 1'b0, ST_MORE,        16'd0},
        '{8'h00,      1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_SEMI,    1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_V,       1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_GT,      1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_SEMI,    1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_L,       1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_GT,      1'b0, 1'b1, ST_MISMATCH,    16'd2},
        '{CH_L,       1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_LT,      1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_SEMI,    1'b0, 1'b1, ST_MISMATCH,    16'd3},
        '{CH_L,       1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_LT,      1'b0, 1'b0, ST_MORE,        16'd0},
        '{CH_LOWER_X, 1'b1, 1'b1, ST_BAD_GENERIC, 16'd3}
    };

    java_type_signature_scanner i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_char_in   (char_in),
        .i_last_byte (last_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_consumed  (consumed)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Advance the scanner model by one byte and return the result it gives
    task automatic scan_signature_byte(input logic [7:0] c, input logic last,
                                       output t_scan_result r);
        t_status st;
        t_mark   top;
        st = ST_MORE;
        if (pass_bytes != CNT_MAX) pass_bytes = pass_bytes + CNT_W'(1);
        if (sig_mode != MODE_BODY) begin
            if (c == CH_BRACKET) begin
                sig_mode = MODE_BRACKETS;
            end else if (c == CH_V) begin
                st = ST_DONE;
            end else if (c == CH_L) begin
                mark_stack[0] = MARK_L;
                mark_level    = 1;
                sig_mode      = MODE_BODY;
            end else begin
                st = ST_BAD_TOP;
            end
        end else begin
            top = mark_stack[mark_level - 1];
            if (c == CH_SEMI) begin
                mark_level--;
                if (top != MARK_L) st = ST_MISMATCH;
                else if (mark_level == 0) st = ST_DONE;
            end else if (c == CH_LT) begin
                if (mark_level >= NEST_DEPTH) begin
                    st = ST_OVERFLOW;
                end else begin
                    mark_stack[mark_level] = MARK_ANGLE;
                    mark_level++;
                end
            end else if (c == CH_GT) begin
                mark_level--;
                if (top != MARK_ANGLE) st = ST_MISMATCH;
            end else if (top == MARK_L) begin
                // name byte: nothing changes
            end else if (c == CH_L) begin
                if (mark_level >= NEST_DEPTH) begin
                    st = ST_OVERFLOW;
                end else begin
                    mark_stack[mark_level] = MARK_L;
                    mark_level++;
                end
            end else if (c != CH_V && c != CH_STAR) begin
                st = ST_BAD_GENERIC;
            end
        end
        if (st == ST_MORE && last) st = ST_TRUNCATED;
        r.st   = st;
        r.cons = (st == ST_MORE || st == ST_BAD_TOP || st == ST_TRUNCATED) ? '0 : pass_bytes;
        // End of pass: back to idle
        if (st != ST_MORE) begin
            sig_mode   = MODE_IDLE;
            mark_level = 0;
            pass_bytes = '0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_SEMI || c == CH_LT || c == CH_GT);
        return c;
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 6))
            0: return CH_SEMI;
            1: return CH_GT;
            2: return CH_LT;
            3: return CH_L;
            4: return CH_V;
            5: return CH_STAR;
            default: return CH_BRACKET;
        endcase
    endfunction

    // Offer one item, hold it until accepted, then record what it should give
    task automatic send_byte(input logic [7:0] c, input logic last, input logic typed,
                             input t_status st, input logic [CNT_W-1:0] cons);
        int           gap;
        t_scan_result r;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        char_in   <= c;
        last_byte <= last;
        do @(posedge clk); while (in_stall);
        scan_signature_byte(c, last, r);
        if (typed) begin
            r.st   = st;
            r.cons = cons;
        end
        pending_results.push_back(r);
        n_items_in++;
    endtask

    task automatic flush_seq();
        foreach (seq_bytes[k]) send_byte(seq_bytes[k][7:0], seq_bytes[k][8], 1'b0, ST_MORE, '0);
        seq_bytes.delete();
    endtask

    // Random walk over a well-formed signature, nesting held to max_depth
    task automatic gen_signature(input int max_depth, input int max_len);
        t_mark gstack [NEST_DEPTH];
        int    glevel;
        int    steps;
        int    nbr;
        logic  closing;
        nbr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        repeat (nbr) seq_bytes.push_back({1'b0, CH_BRACKET});
        if ($urandom_range(0, 7) == 0) begin
            seq_bytes.push_back({1'b0, CH_V});
            return;
        end
        seq_bytes.push_back({1'b0, CH_L});
        gstack[0] = MARK_L;
        glevel    = 1;
        steps     = 0;
        while (glevel > 0) begin
            steps++;
            closing = (steps > max_len) || ($urandom_range(0, 3) == 0);
            if (gstack[glevel - 1] == MARK_L) begin
                if (closing) begin
                    seq_bytes.push_back({1'b0, CH_SEMI});
                    glevel--;
                end else if (glevel < max_depth && $urandom_range(0, 3) == 0) begin
                    seq_bytes.push_back({1'b0, CH_LT});
                    gstack[glevel] = MARK_ANGLE;
                    glevel++;
                end else begin
                    seq_bytes.push_back({1'b0, name_byte()});
                end
            end else begin
                if (closing) begin
                    seq_bytes.push_back({1'b0, CH_GT});
                    glevel--;
                end else if (glevel < max_depth && $urandom_range(0, 1) == 0) begin
                    seq_bytes.push_back({1'b0, CH_L});
                    gstack[glevel] = MARK_L;
                    glevel++;
                end else begin
                    seq_bytes.push_back({1'b0, ($urandom_range(0, 1) == 0) ? CH_V : CH_STAR});
                end
            end
        end
    endtask

    // Nest to target marks and close them if within depth; one past the stack depth overflows
    task automatic gen_deep(input int target);
        int lvl;
        seq_bytes.push_back({1'b0, CH_L});
        lvl = 1;
        while (lvl < target) begin
            if (lvl % 2 == 1) begin
                if ($urandom_range(0, 2) == 0) seq_bytes.push_back({1'b0, name_byte()});
                seq_bytes.push_back({1'b0, CH_LT});
            end else begin
                if ($urandom_range(0, 2) == 0) seq_bytes.push_back({1'b0, CH_STAR});
                seq_bytes.push_back({1'b0, CH_L});
            end
            lvl++;
        end
        if (target <= NEST_DEPTH) begin
            for (lvl = target; lvl > 0; lvl--)
                seq_bytes.push_back({1'b0, (lvl % 2 == 1) ? CH_SEMI : CH_GT});
        end
    endtask

    // Receiver: random stall stretches, plus one long hold-off
    initial begin : receiver
        int   len;
        logic lvl;
        logic held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (!held && n_items_in >= HOLD_AFTER) begin
                held = 1'b1;
                lvl  = 1'b1;
                len  = HOLD_CYCLES;
            end else if ($urandom_range(0, 2) == 0) begin
                lvl = 1'b0;
                len = $urandom_range(5, 30);
            end else begin
                lvl = 1'($urandom_range(0, 1));
                len = (lvl && $urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                         : $urandom_range(1, 3);
            end
            repeat (len) begin
                @(negedge clk);
                out_stall <= lvl;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin : check_results
        t_scan_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d consumed %0d",
                         $time, status, consumed);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (status !== want.st) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.st, status);
                    n_fail++;
                end
                if (consumed !== want.cons) begin
                    $display("%0t: consumed mismatch, expected %0d actual %0d",
                             $time, want.cons, consumed);
                    n_fail++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int seq_no;
        int pick;
        int idx;
        int n;
        sig_mode   = MODE_IDLE;
        mark_level = 0;
        pass_bytes = '0;
        foreach (mark_stack[k]) mark_stack[k] = MARK_L;

        // Hold reset, then release
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[k])
            send_byte(directed_rows[k].ch, directed_rows[k].last, directed_rows[k].typed,
                      directed_rows[k].st, directed_rows[k].cons);

        // Random signatures: mostly well-formed, some broken, some noise
        seq_no = 0;
        while (n_items_in < DIR_ROWS + RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            pick  = $urandom_range(0, 99);
            if (seq_no == 3) begin
                gen_deep(NEST_DEPTH + 1);
                pick = 0;
            end else if (seq_no == 9) begin
                gen_deep(NEST_DEPTH);
                pick = 0;
            end else if (pick < 60) begin
                gen_signature($urandom_range(1, 4), $urandom_range(2, 12));
            end else if (pick < 66) begin
                gen_signature(NEST_DEPTH, 80);
            end else if (pick < 70) begin
                gen_deep(NEST_DEPTH + $urandom_range(0, 1));
            end else if (pick < 85) begin
                gen_signature($urandom_range(1, 4), $urandom_range(2, 12));
                idx = $urandom_range(0, seq_bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0: seq_bytes[idx] = {1'b1, seq_bytes[idx][7:0]};
                    1: seq_bytes[idx] = {1'b0, 8'($urandom)};
                    default: seq_bytes.insert(idx, {1'b0, special_byte()});
                endcase
            end else begin
                repeat ($urandom_range(1, 6))
                    seq_bytes.push_back({1'($urandom_range(0, 3) == 0), 8'($urandom)});
            end
            // Mark the closing byte as the buffer end now and then
            if (pick < 70 && $urandom_range(0, 3) == 0) begin
                n = seq_bytes.size() - 1;
                seq_bytes[n] = {1'b1, seq_bytes[n][7:0]};
            end
            flush_seq();
            seq_no++;
        end
        burst = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain outstanding results
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
